[hdl/bcch_pkg.sv]
// package: block type, cipher constants, round function
`timescale 1ns / 1ps

package bcch_pkg;

  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned BLOCK_BITS  = 8 * BLOCK_BYTES;
  localparam int unsigned HALF_BITS   = BLOCK_BITS / 2;

  // last word of a block and last round of a compression
  localparam logic [1:0] WORD_LAST  = 2'd3;
  localparam logic [1:0] ROUND_LAST = 2'd3;

  localparam logic [BLOCK_BITS-1:0] INIT_H = {
    64'hdd6764594e0aa55a, 64'h8620c189c43064bc,
    64'h69a2c58b8320e652, 64'h52f6edd2afee540d
  };

  localparam logic [7:0] SBOX [256] = '{
    8'd185, 8'd226, 8'd243, 8'd232, 8'd46,  8'd37,  8'd100, 8'd127,
    8'd108, 8'd119, 8'd38,  8'd61,  8'd251, 8'd224, 8'd177, 8'd170,
    8'd186, 8'd176, 8'd225, 8'd250, 8'd60,  8'd39,  8'd118, 8'd109,
    8'd126, 8'd101, 8'd52,  8'd111, 8'd233, 8'd121, 8'd163, 8'd164,
    8'd215, 8'd204, 8'd157, 8'd6,   8'd64,  8'd91,  8'd138, 8'd145,
    8'd2,   8'd25,  8'd72,  8'd83,  8'd149, 8'd142, 8'd223, 8'd196,
    8'd197, 8'd222, 8'd143, 8'd148, 8'd82,  8'd73,  8'd24,  8'd3,
    8'd16,  8'd11,  8'd90,  8'd65,  8'd135, 8'd156, 8'd205, 8'd242,
    8'd159, 8'd132, 8'd213, 8'd206, 8'd8,   8'd19,  8'd66,  8'd89,
    8'd74,  8'd87,  8'd0,   8'd27,  8'd221, 8'd198, 8'd151, 8'd140,
    8'd141, 8'd150, 8'd199, 8'd220, 8'd26,  8'd1,   8'd80,  8'd75,
    8'd88,  8'd67,  8'd18,  8'd9,   8'd207, 8'd212, 8'd133, 8'd158,
    8'd241, 8'd59,  8'd187, 8'd160, 8'd102, 8'd125, 8'd44,  8'd55,
    8'd36,  8'd63,  8'd110, 8'd183, 8'd179, 8'd168, 8'd249, 8'd162,
    8'd227, 8'd248, 8'd169, 8'd178, 8'd116, 8'd95,  8'd62,  8'd53,
    8'd54,  8'd45,  8'd124, 8'd47,  8'd161, 8'd152, 8'd235, 8'd190,
    8'd115, 8'd105, 8'd56,  8'd35,  8'd165, 8'd254, 8'd175, 8'd180,
    8'd167, 8'd188, 8'd237, 8'd246, 8'd48,  8'd43,  8'd122, 8'd97,
    8'd96,  8'd123, 8'd42,  8'd49,  8'd247, 8'd236, 8'd189, 8'd166,
    8'd181, 8'd174, 8'd255, 8'd228, 8'd34,  8'd57,  8'd104, 8'd103,
    8'd28,  8'd7,   8'd86,  8'd77,  8'd139, 8'd144, 8'd193, 8'd218,
    8'd201, 8'd210, 8'd131, 8'd184, 8'd94,  8'd69,  8'd20,  8'd15,
    8'd14,  8'd21,  8'd68,  8'd29,  8'd153, 8'd128, 8'd211, 8'd234,
    8'd219, 8'd192, 8'd17,  8'd10,  8'd76,  8'd85,  8'd134, 8'd171,
    8'd84,  8'd79,  8'd30,  8'd5,   8'd195, 8'd216, 8'd136, 8'd146,
    8'd129, 8'd154, 8'd203, 8'd208, 8'd22,  8'd13,  8'd92,  8'd71,
    8'd70,  8'd93,  8'd12,  8'd23,  8'd209, 8'd202, 8'd155, 8'd130,
    8'd147, 8'd137, 8'd217, 8'd194, 8'd4,   8'd31,  8'd78,  8'd200,
    8'd58,  8'd33,  8'd112, 8'd107, 8'd173, 8'd182, 8'd230, 8'd252,
    8'd239, 8'd50,  8'd229, 8'd172, 8'd120, 8'd99,  8'd114, 8'd41,
    8'd40,  8'd51,  8'd98,  8'd113, 8'd191, 8'd214, 8'd245, 8'd244,
    8'd253, 8'd231, 8'd117, 8'd32,  8'd106, 8'd81,  8'd240, 8'd238
  };

  typedef struct packed {
    logic [BLOCK_BITS-1:0] msg;
    logic                  fin;
  } blk_t;

  // key xor, byte substitution, then bit p takes bit (35p+57) mod 128
  // bit 0 is the msb of byte 0, i.e. vector bit 127
  function automatic logic [HALF_BITS-1:0] f_round(logic [HALF_BITS-1:0] x,
                                                   logic [HALF_BITS-1:0] k);
    logic [HALF_BITS-1:0] xk;
    logic [HALF_BITS-1:0] t;
    logic [HALF_BITS-1:0] o;
    int unsigned q;
    xk = x ^ k;
    for (int i = 0; i < HALF_BITS / 8; i++) begin
      t[HALF_BITS-1-8*i -: 8] = SBOX[xk[HALF_BITS-1-8*i -: 8]];
    end
    for (int p = 0; p < HALF_BITS; p++) begin
      q = (35 * p + 57) % HALF_BITS;
      o[HALF_BITS-1-p] = t[HALF_BITS-1-q];
    end
    return o;
  endfunction

endpackage

[hdl/bcch_if.sv]
// channel interfaces: message words in, digest words out
`timescale 1ns / 1ps

interface bcch_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic        final_block;

  modport source (output valid, output message_word, output final_block, input ready);
  modport sink   (input valid, input message_word, input final_block, output ready);
endinterface

interface bcch_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

[hdl/block_cipher_chained_hash.sv]
// top level: word collector, block queue and compression engine
// takes one message word per cycle unless a block's fourth word finds the queue full
// the engine runs four cipher rounds per block; a final block's digest is 4 words
// one word leaves per ready cycle; a second final digest may wait for the first to drain
// reset: chaining value returns to the initial value, queue and counters empty
`timescale 1ns / 1ps

module block_cipher_chained_hash (
  input  logic          clk_i,
  input  logic          rst_ni,
  bcch_word_if.sink     word_i,
  bcch_digest_if.source digest_o
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  bcch_pkg::blk_t push_blk, pop_blk;

  bcch_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_blk_o   (push_blk)
  );

  bcch_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_blk_i   (push_blk),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_blk_o    (pop_blk)
  );

  bcch_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (pop_valid),
    .blk_ready_o (pop_ready),
    .blk_i       (pop_blk),
    .digest_o    (digest_o)
  );

`ifndef SYNTHESIS
  // input stalls only when a block cannot enter the queue
  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !word_i.ready |-> !push_ready)
    else $error("input stalled with queue space free");

  // a digest always starts with its first word
  a_digest_starts_at_word0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(digest_o.valid) |-> !digest_o.last_word)
    else $error("digest began at its last word");

  // the engine is busy for the cycle after it takes a block
  a_engine_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |=> !pop_ready)
    else $error("engine took blocks in back-to-back cycles");
`endif

endmodule

[hdl/bcch_front.sv]
// front end: gathers four message words into one block
`timescale 1ns / 1ps

module bcch_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcch_word_if.sink         word_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output bcch_pkg::blk_t    push_blk_o
);

  logic [1:0]                     pos_q, pos_d;
  logic [bcch_pkg::WORD_BITS-1:0] buf_q [3];
  logic                           is_last;
  logic                           fire;

  assign is_last      = (pos_q == bcch_pkg::WORD_LAST);
  // first three words only need buffer space, the fourth needs a queue slot
  assign word_i.ready = !is_last || push_ready_i;
  assign fire         = word_i.valid && word_i.ready;
  assign push_valid_o = word_i.valid && is_last;

  always_comb begin
    push_blk_o.msg = {buf_q[0], buf_q[1], buf_q[2], word_i.message_word};
    push_blk_o.fin = word_i.final_block;
  end

  always_comb begin
    pos_d = pos_q;
    if (fire) begin
      pos_d = pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !is_last) begin
      buf_q[pos_q] <= word_i.message_word;
    end
  end

endmodule

[hdl/bcch_queue.sv]
// two-entry block queue between front end and compression engine
`timescale 1ns / 1ps

module bcch_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  bcch_pkg::blk_t    push_blk_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output bcch_pkg::blk_t    pop_blk_o
);

  bcch_pkg::blk_t mem_q [2];
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_blk_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_blk_i;
    end
  end

endmodule

[hdl/bcch_engine.sv]
// back end: a cipher round per unstalled cycle, chaining value update, digest output
`timescale 1ns / 1ps

module bcch_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              blk_valid_i,
  output logic              blk_ready_o,
  input  bcch_pkg::blk_t    blk_i,
  bcch_digest_if.source     digest_o
);

  localparam int unsigned HB = bcch_pkg::HALF_BITS;
  localparam int unsigned BB = bcch_pkg::BLOCK_BITS;

  logic [BB-1:0] h_q, h_d;
  logic [BB-1:0] s_q;
  logic [BB-1:0] m_q;
  logic          fin_q;
  logic          busy_q, busy_d;
  logic [1:0]    rnd_q, rnd_d;
  logic [BB-1:0] dig_q;
  logic          dig_valid_q, dig_valid_d;
  logic [1:0]    cnt_q, cnt_d;

  logic [HB-1:0] lo_l, lo_r, key, f_in, f_out;
  logic [BB-1:0] s_next, h_new;
  logic          dig_free, last_rnd, finishing, take, out_fire;

  // round 0,1 feistel and 2,3 lai-massey; odd rounds use the second key half
  always_comb begin
    lo_l  = s_q[BB-1:HB];
    lo_r  = s_q[HB-1:0];
    key   = rnd_q[0] ? m_q[HB-1:0] : m_q[BB-1:HB];
    f_in  = rnd_q[1] ? (lo_l ^ lo_r) : lo_r;
    f_out = bcch_pkg::f_round(f_in, key);
    s_next = rnd_q[1] ? {lo_l ^ f_out, lo_r ^ f_out} : {lo_r, f_out ^ lo_l};
    h_new  = h_q ^ s_next;
  end

  assign out_fire  = digest_o.valid && digest_o.ready;
  assign dig_free  = !dig_valid_q || (out_fire && cnt_q == bcch_pkg::WORD_LAST);
  assign last_rnd  = busy_q && (rnd_q == bcch_pkg::ROUND_LAST);
  // a final block waits in its last round until the digest register is free
  assign finishing = last_rnd && (!fin_q || dig_free);
  assign take      = blk_valid_i && (!busy_q || finishing);
  assign blk_ready_o = !busy_q || finishing;

  always_comb begin
    h_d = h_q;
    if (finishing) begin
      h_d = fin_q ? bcch_pkg::INIT_H : h_new;
    end
  end

  always_comb begin
    busy_d = busy_q;
    rnd_d  = rnd_q;
    if (take) begin
      busy_d = 1'b1;
      rnd_d  = 2'd0;
    end else if (finishing) begin
      busy_d = 1'b0;
    end else if (busy_q && !last_rnd) begin
      rnd_d = rnd_q + 2'd1;
    end
  end

  always_comb begin
    dig_valid_d = dig_valid_q;
    cnt_d       = cnt_q;
    if (out_fire) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == bcch_pkg::WORD_LAST) begin
        dig_valid_d = 1'b0;
      end
    end
    if (finishing && fin_q) begin
      dig_valid_d = 1'b1;
      cnt_d       = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q         <= bcch_pkg::INIT_H;
      busy_q      <= 1'b0;
      rnd_q       <= 2'd0;
      dig_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      h_q         <= h_d;
      busy_q      <= busy_d;
      rnd_q       <= rnd_d;
      dig_valid_q <= dig_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s_q   <= h_d;
      m_q   <= blk_i.msg;
      fin_q <= blk_i.fin;
    end else if (busy_q && !last_rnd) begin
      s_q <= s_next;
    end
    if (finishing && fin_q) begin
      dig_q <= h_new;
    end
  end

  assign digest_o.valid     = dig_valid_q;
  assign digest_o.last_word = (cnt_q == bcch_pkg::WORD_LAST);

  always_comb begin
    case (cnt_q)
      2'd0:    digest_o.digest_word = dig_q[255:192];
      2'd1:    digest_o.digest_word = dig_q[191:128];
      2'd2:    digest_o.digest_word = dig_q[127:64];
      default: digest_o.digest_word = dig_q[63:0];
    endcase
  end

endmodule
